>>> design/pse_pkg.sv
// Shared types, constants and helper functions for the stored-block PNG encoder.
// Used by the front, queue, back and top-level modules. No dependencies.
package pse_pkg;

    localparam int unsigned MAX_DIM   = 16384;
    localparam int unsigned BLOCK_LEN = 65535;
    localparam int unsigned ADLER_MOD = 65521;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned PADDR_W     = 4;

    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_CHANNELS = 2'd2;

    localparam logic [31:0] CRC_POLY  = 32'hedb88320;
    localparam logic [31:0] CRC_INIT  = 32'hffffffff;
    localparam logic [31:0] IEND_CRC  = 32'hae426082;

    localparam logic [5:0] HDR_LAST = 6'd42;
    localparam logic [5:0] BH_LAST  = 6'd4;
    localparam logic [5:0] TRL_LAST = 6'd19;

    // One queued work word: what the back end has to emit for one sample.
    typedef struct packed {
        logic [7:0]  sample;
        logic        err;
        logic        hdr;
        logic        bh1;
        logic        filt;
        logic        bh2;
        logic        trl;
        logic        fin;
        logic [15:0] blk_len;
    } job_t;

    // Image geometry derived from the configuration registers.
    typedef struct packed {
        logic [14:0] width;
        logic [14:0] height;
        logic [7:0]  ctype;
        logic [31:0] idat_len;
    } img_info_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
        end
        return r;
    endfunction

endpackage

>>> design/pse_front.sv
// Front end: configuration registers, image geometry, and per-sample
// classification into queued work words. Depends on pse_pkg.
module pse_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pse_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    input  logic                         in_push,
    input  logic [7:0]                   in_sample,
    output logic                         cfg_busy,
    output pse_pkg::job_t                job,
    output pse_pkg::img_info_t           info
);

    localparam logic [1:0] REG_WIDTH_SEL    = pse_pkg::REG_WIDTH;
    localparam logic [1:0] REG_HEIGHT_SEL   = pse_pkg::REG_HEIGHT;
    localparam logic [1:0] REG_CHANNELS_SEL = pse_pkg::REG_CHANNELS;

    logic [14:0] width_reg;
    logic [14:0] height_reg;
    logic [2:0]  chan_reg;
    logic [2:0]  hold_reg;

    logic [14:0] wc_reg;
    logic [14:0] hc_reg;
    logic [16:0] row_len_reg;
    logic [30:0] raw_total_reg;
    logic [16:0] nblocks_reg;
    logic [31:0] idat_len_reg;
    logic [7:0]  ctype_reg;

    logic [30:0] sp_reg, sp_next;
    logic [16:0] rp_reg, rp_next;
    logic [15:0] bp_reg, bp_next;
    logic        hs_reg, hs_next;

    logic        wr_en;
    logic        ch_ok;
    logic [14:0] wc_c;
    logic [14:0] hc_c;
    logic [16:0] row_len_c;
    logic [32:0] tdiv;
    logic [32:0] qdiv;

    assign wr_en = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH_SEL:    prdata = {17'd0, width_reg};
            REG_HEIGHT_SEL:   prdata = {17'd0, height_reg};
            REG_CHANNELS_SEL: prdata = {29'd0, chan_reg};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 15'd64;
            height_reg <= 15'd64;
            chan_reg   <= 3'd3;
        end else if (wr_en) begin
            if (paddr[3:2] == pse_pkg::REG_WIDTH) begin
                width_reg <= pwdata[14:0];
            end
            if (paddr[3:2] == pse_pkg::REG_HEIGHT) begin
                height_reg <= pwdata[14:0];
            end
            if (paddr[3:2] == pse_pkg::REG_CHANNELS) begin
                chan_reg <= pwdata[2:0];
            end
        end
    end

    // Input is held off after reset or a register write until the geometry pipeline
    // has settled.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= 3'd4;
        end else if (wr_en) begin
            hold_reg <= 3'd4;
        end else if (hold_reg != 3'd0) begin
            hold_reg <= hold_reg - 3'd1;
        end
    end

    assign cfg_busy = (hold_reg != 3'd0);

    assign ch_ok = (chan_reg == 3'd1) || (chan_reg == 3'd3) || (chan_reg == 3'd4);

    always_comb begin
        if (width_reg < 15'd8) begin
            wc_c = 15'd8;
        end else if (width_reg > 15'(pse_pkg::MAX_DIM)) begin
            wc_c = 15'(pse_pkg::MAX_DIM);
        end else begin
            wc_c = width_reg;
        end
        if (height_reg < 15'd1) begin
            hc_c = 15'd1;
        end else if (height_reg > 15'(pse_pkg::MAX_DIM)) begin
            hc_c = 15'(pse_pkg::MAX_DIM);
        end else begin
            hc_c = height_reg;
        end
        case (chan_reg)
            3'd3:    row_len_c = {2'd0, wc_c} + {1'b0, wc_c, 1'b0} + 17'd1;
            3'd4:    row_len_c = {wc_c, 2'b00} + 17'd1;
            default: row_len_c = {2'd0, wc_c} + 17'd1;
        endcase
    end

    // Blocks = ceil(raw / 65535); divide by 65535 via (t + t/65536 + 1) / 65536.
    assign tdiv = {2'd0, raw_total_reg} + 33'(pse_pkg::BLOCK_LEN - 1);
    assign qdiv = tdiv + {16'd0, tdiv[32:16]} + 33'd1;

    // Geometry pipeline; the user must change registers only while the block is idle; unchecked.
    always_ff @(posedge aclk) begin
        wc_reg        <= wc_c;
        hc_reg        <= hc_c;
        row_len_reg   <= row_len_c;
        raw_total_reg <= 31'(row_len_reg * hc_reg);
        nblocks_reg   <= qdiv[32:16];
        idat_len_reg  <= {1'b0, raw_total_reg} + 32'(nblocks_reg) * 32'd5 + 32'd6;
        case (chan_reg)
            3'd3:    ctype_reg <= 8'd2;
            3'd4:    ctype_reg <= 8'd6;
            default: ctype_reg <= 8'd0;
        endcase
    end

    assign info.width    = wc_reg;
    assign info.height   = hc_reg;
    assign info.ctype    = ctype_reg;
    assign info.idat_len = idat_len_reg;

    logic        filt, bh1, bh2, trl;
    logic [15:0] bp1, bp2;
    logic [30:0] sp1, sp2, sp_eff, rem;
    logic [16:0] rp2;
    logic        more;

    always_comb begin
        filt   = (rp_reg == 17'd0);
        bh1    = filt && (bp_reg == 16'd0);
        bp1    = bp_reg;
        if (filt) begin
            bp1 = (bp_reg == 16'(pse_pkg::BLOCK_LEN - 1)) ? 16'd0 : bp_reg + 16'd1;
        end
        sp1    = sp_reg + {30'd0, filt};
        bh2    = (bp1 == 16'd0);
        bp2    = (bp1 == 16'(pse_pkg::BLOCK_LEN - 1)) ? 16'd0 : bp1 + 16'd1;
        sp2    = sp1 + 31'd1;
        rp2    = (filt ? 17'd1 : rp_reg) + 17'd1;
        trl    = (sp2 >= raw_total_reg);
        sp_eff = bh1 ? sp_reg : sp1;
        more   = raw_total_reg > sp_eff;
        rem    = raw_total_reg - sp_eff;

        job.sample  = in_sample;
        job.err     = !ch_ok;
        job.hdr     = !hs_reg;
        job.bh1     = bh1;
        job.filt    = filt;
        job.bh2     = bh2;
        job.trl     = trl;
        job.fin     = !more || (rem <= 31'(pse_pkg::BLOCK_LEN));
        if (!more) begin
            job.blk_len = 16'd1;
        end else if (rem < 31'(pse_pkg::BLOCK_LEN)) begin
            job.blk_len = rem[15:0];
        end else begin
            job.blk_len = 16'(pse_pkg::BLOCK_LEN);
        end

        sp_next = sp_reg;
        rp_next = rp_reg;
        bp_next = bp_reg;
        hs_next = hs_reg;
        if (in_push && ch_ok) begin
            if (trl) begin
                sp_next = 31'd0;
                rp_next = 17'd0;
                bp_next = 16'd0;
                hs_next = 1'b0;
            end else begin
                sp_next = sp2;
                rp_next = (rp2 >= row_len_reg) ? 17'd0 : rp2;
                bp_next = bp2;
                hs_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg <= 31'd0;
            rp_reg <= 17'd0;
            bp_reg <= 16'd0;
            hs_reg <= 1'b0;
        end else begin
            sp_reg <= sp_next;
            rp_reg <= rp_next;
            bp_reg <= bp_next;
            hs_reg <= hs_next;
        end
    end

endmodule

>>> design/pse_queue.sv
// Short first-in first-out queue of work words between front and back end.
// Depends on pse_pkg.
module pse_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  pse_pkg::job_t  push_job,
    input  logic           pop,
    output pse_pkg::job_t  head_job,
    output logic           full,
    output logic           empty
);

    pse_pkg::job_t entry_reg [pse_pkg::QUEUE_DEPTH];
    logic [pse_pkg::QUEUE_AW-1:0] wp_reg, rp_reg;
    logic [pse_pkg::QUEUE_AW:0]   cnt_reg;

    assign full     = (cnt_reg == (pse_pkg::QUEUE_AW+1)'(pse_pkg::QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign head_job = entry_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wp_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

>>> design/pse_back.sv
// Back end: expands queued work words into PNG bytes, one per cycle unless
// m_ready stalls, and keeps the running CRC-32 and Adler-32. Depends on pse_pkg.
module pse_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  pse_pkg::job_t      head_job,
    input  logic               empty,
    output logic               pop,
    input  pse_pkg::img_info_t info,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_last_of_run,
    output logic               m_end_of_file,
    output logic               m_format_error
);

    typedef enum logic [2:0] {
        PH_HDR, PH_BH1, PH_FILT, PH_BH2, PH_SAMP, PH_TRL, PH_ERR, PH_DONE
    } phase_t;

    phase_t      phase_reg;
    logic        start_reg;
    logic [5:0]  idx_reg;
    logic [31:0] crc_reg;
    logic [15:0] alo_reg;
    logic [15:0] ahi_reg;
    logic        mv_reg;
    logic [7:0]  mb_reg;
    logic        ml_reg, me_reg, mf_reg;

    phase_t      cur_ph, nxt_ph;
    logic [5:0]  cur_idx;
    logic [5:0]  last_idx;
    logic        adv, emit, at_last;
    logic [7:0]  b;
    logic        use_crc, crc_rst, use_adler;
    logic [31:0] crc_base;
    logic [15:0] nlen;
    logic [16:0] lo_sum, hi_sum;
    logic [15:0] alo_new, ahi_new;

    always_comb begin
        if (head_job.err) begin
            cur_ph = PH_ERR;
        end else if (head_job.hdr) begin
            cur_ph = PH_HDR;
        end else if (head_job.bh1) begin
            cur_ph = PH_BH1;
        end else if (head_job.filt) begin
            cur_ph = PH_FILT;
        end else if (head_job.bh2) begin
            cur_ph = PH_BH2;
        end else begin
            cur_ph = PH_SAMP;
        end
        if (!start_reg) begin
            cur_ph = phase_reg;
        end
        cur_idx = start_reg ? 6'd0 : idx_reg;

        case (cur_ph)
            PH_HDR:  nxt_ph = head_job.bh1 ? PH_BH1 : (head_job.filt ? PH_FILT :
                              (head_job.bh2 ? PH_BH2 : PH_SAMP));
            PH_BH1:  nxt_ph = PH_FILT;
            PH_FILT: nxt_ph = head_job.bh2 ? PH_BH2 : PH_SAMP;
            PH_BH2:  nxt_ph = PH_SAMP;
            PH_SAMP: nxt_ph = head_job.trl ? PH_TRL : PH_DONE;
            default: nxt_ph = PH_DONE;
        endcase

        case (cur_ph)
            PH_HDR:  last_idx = pse_pkg::HDR_LAST;
            PH_BH1:  last_idx = pse_pkg::BH_LAST;
            PH_BH2:  last_idx = pse_pkg::BH_LAST;
            PH_TRL:  last_idx = pse_pkg::TRL_LAST;
            default: last_idx = 6'd0;
        endcase
        at_last = (cur_idx == last_idx);
    end

    always_comb begin
        b         = 8'd0;
        use_crc   = 1'b0;
        crc_rst   = 1'b0;
        use_adler = 1'b0;
        nlen      = ~head_job.blk_len;
        case (cur_ph)
            PH_HDR: begin
                case (cur_idx)
                    6'd0:  b = 8'd137;
                    6'd1:  b = 8'd80;
                    6'd2:  b = 8'd78;
                    6'd3:  b = 8'd71;
                    6'd4:  b = 8'd13;
                    6'd5:  b = 8'd10;
                    6'd6:  b = 8'd26;
                    6'd7:  b = 8'd10;
                    6'd11: b = 8'd13;
                    6'd12: b = 8'h49;
                    6'd13: b = 8'h48;
                    6'd14: b = 8'h44;
                    6'd15: b = 8'h52;
                    6'd18: b = {1'b0, info.width[14:8]};
                    6'd19: b = info.width[7:0];
                    6'd22: b = {1'b0, info.height[14:8]};
                    6'd23: b = info.height[7:0];
                    6'd24: b = 8'd8;
                    6'd25: b = info.ctype;
                    6'd29: b = ~crc_reg[31:24];
                    6'd30: b = ~crc_reg[23:16];
                    6'd31: b = ~crc_reg[15:8];
                    6'd32: b = ~crc_reg[7:0];
                    6'd33: b = info.idat_len[31:24];
                    6'd34: b = info.idat_len[23:16];
                    6'd35: b = info.idat_len[15:8];
                    6'd36: b = info.idat_len[7:0];
                    6'd37: b = 8'h49;
                    6'd38: b = 8'h44;
                    6'd39: b = 8'h41;
                    6'd40: b = 8'h54;
                    6'd41: b = 8'h78;
                    6'd42: b = 8'h01;
                    default: b = 8'd0;
                endcase
                use_crc = ((cur_idx >= 6'd12) && (cur_idx <= 6'd28)) || (cur_idx >= 6'd37);
                crc_rst = (cur_idx == 6'd12) || (cur_idx == 6'd37);
            end
            PH_BH1, PH_BH2: begin
                case (cur_idx)
                    6'd0:    b = {7'd0, head_job.fin};
                    6'd1:    b = head_job.blk_len[7:0];
                    6'd2:    b = head_job.blk_len[15:8];
                    6'd3:    b = nlen[7:0];
                    default: b = nlen[15:8];
                endcase
                use_crc = 1'b1;
            end
            PH_FILT: begin
                b         = 8'd0;
                use_crc   = 1'b1;
                use_adler = 1'b1;
            end
            PH_SAMP: begin
                b         = head_job.sample;
                use_crc   = 1'b1;
                use_adler = 1'b1;
            end
            PH_TRL: begin
                case (cur_idx)
                    6'd0:  b = ahi_reg[15:8];
                    6'd1:  b = ahi_reg[7:0];
                    6'd2:  b = alo_reg[15:8];
                    6'd3:  b = alo_reg[7:0];
                    6'd4:  b = ~crc_reg[31:24];
                    6'd5:  b = ~crc_reg[23:16];
                    6'd6:  b = ~crc_reg[15:8];
                    6'd7:  b = ~crc_reg[7:0];
                    6'd12: b = 8'h49;
                    6'd13: b = 8'h45;
                    6'd14: b = 8'h4e;
                    6'd15: b = 8'h44;
                    6'd16: b = pse_pkg::IEND_CRC[31:24];
                    6'd17: b = pse_pkg::IEND_CRC[23:16];
                    6'd18: b = pse_pkg::IEND_CRC[15:8];
                    6'd19: b = pse_pkg::IEND_CRC[7:0];
                    default: b = 8'd0;
                endcase
                use_crc = (cur_idx <= 6'd3);
            end
            default: b = 8'd0;
        endcase
    end

    assign crc_base = crc_rst ? pse_pkg::CRC_INIT : crc_reg;

    // Adler sums stay below the modulus, so one conditional subtract each.
    always_comb begin
        lo_sum  = {1'b0, alo_reg} + {9'd0, b};
        alo_new = (lo_sum >= 17'(pse_pkg::ADLER_MOD)) ?
                  16'(lo_sum - 17'(pse_pkg::ADLER_MOD)) : lo_sum[15:0];
        hi_sum  = {1'b0, ahi_reg} + {1'b0, alo_new};
        ahi_new = (hi_sum >= 17'(pse_pkg::ADLER_MOD)) ?
                  16'(hi_sum - 17'(pse_pkg::ADLER_MOD)) : hi_sum[15:0];
    end

    assign adv  = !mv_reg || m_ready;
    assign emit = adv && !empty;
    assign pop  = emit && at_last && (nxt_ph == PH_DONE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= 1'b1;
            phase_reg <= PH_DONE;
            idx_reg   <= 6'd0;
            crc_reg   <= pse_pkg::CRC_INIT;
            alo_reg   <= 16'd1;
            ahi_reg   <= 16'd0;
            mv_reg    <= 1'b0;
        end else begin
            if (emit) begin
                mv_reg <= 1'b1;
                if (at_last) begin
                    idx_reg   <= 6'd0;
                    phase_reg <= nxt_ph;
                    start_reg <= (nxt_ph == PH_DONE);
                end else begin
                    idx_reg   <= cur_idx + 6'd1;
                    phase_reg <= cur_ph;
                    start_reg <= 1'b0;
                end
                if (cur_ph == PH_TRL && at_last) begin
                    crc_reg <= pse_pkg::CRC_INIT;
                    alo_reg <= 16'd1;
                    ahi_reg <= 16'd0;
                end else begin
                    if (use_crc) begin
                        crc_reg <= pse_pkg::crc_byte(crc_base, b);
                    end
                    if (use_adler) begin
                        alo_reg <= alo_new;
                        ahi_reg <= ahi_new;
                    end
                end
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            mb_reg <= b;
            ml_reg <= pop;
            me_reg <= (cur_ph == PH_TRL) && at_last;
            mf_reg <= (cur_ph == PH_ERR);
        end
    end

    assign m_valid        = mv_reg;
    assign m_out_byte     = mb_reg;
    assign m_last_of_run  = ml_reg;
    assign m_end_of_file  = me_reg;
    assign m_format_error = mf_reg;

endmodule

>>> design/png_stored_encoder.sv
// Stored-block PNG encoder: one sample word in, the PNG file out as byte words.
// The first byte of an accepted sample passes the queue and the output register.
// Throughput: one output byte per cycle while m_ready is high; a plain sample gives
// one byte, the first sample of an image adds 43 header bytes, a row start adds a
// filter byte, a block start adds 5 more, the last sample adds 20 trailer bytes,
// set by the sequencer. Reset (aresetn low, synchronous) restores default registers
// and an empty queue; input is held off after reset and after each register write.
module png_stored_encoder (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pse_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_sample_byte,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_out_byte,
    output logic                         m_last_of_run,
    output logic                         m_end_of_file,
    output logic                         m_format_error
);

    pse_pkg::job_t      new_job;
    pse_pkg::job_t      head_job;
    pse_pkg::img_info_t info;
    logic               push, pop, full, empty;
    logic               cfg_busy;

    assign pready  = 1'b1;
    assign s_ready = !full && !cfg_busy;
    assign push    = s_valid && s_ready;

    pse_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .in_push   (push),
        .in_sample (s_sample_byte),
        .cfg_busy  (cfg_busy),
        .job       (new_job),
        .info      (info)
    );

    pse_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (new_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (full),
        .empty    (empty)
    );

    pse_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_job       (head_job),
        .empty          (empty),
        .pop            (pop),
        .info           (info),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_last_of_run  (m_last_of_run),
        .m_end_of_file  (m_end_of_file),
        .m_format_error (m_format_error)
    );

endmodule
